// ===== rtl/mtk_pkg.sv =====
package mtk_pkg;

   localparam int WORD_W = 64;
   localparam int BYTE_W = 8;
   localparam int MT_N   = 312;
   localparam int MT_M   = 156;
   localparam int IDX_W  = $clog2(MT_N);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam word_type MT_MATRIX   = 64'hB502_6F5A_A966_19E9;
   localparam word_type MT_UPPER    = 64'hFFFF_FFFF_8000_0000;
   localparam word_type MT_LOWER    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [31:0] INIT_LO  = 32'h4C95_7F2D;
   localparam logic [31:0] INIT_HI  = 32'h5851_F42D;
   localparam idx_type LAST_IDX     = idx_type'(MT_N - 1);

   typedef struct packed {
      logic push;
      logic busy;
   } seed_status_type;

endpackage

// ===== rtl/mtk_cell.sv =====
module mtk_cell (
   input  logic              clock,
   input  logic              en,
   input  mtk_pkg::word_type d,
   output mtk_pkg::word_type q
);
   import mtk_pkg::*;

   word_type word_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= d;
      end
   end

   assign q = word_ff;

endmodule

// ===== rtl/mtk_seed_gen.sv =====
module mtk_seed_gen (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  mtk_pkg::word_type        seed,
   input  mtk_pkg::word_type        tail,
   output mtk_pkg::word_type        word,
   output mtk_pkg::seed_status_type status
);
   import mtk_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_PUSH
   } state_type;

   state_type   state_ff;
   idx_type     idx_ff;
   word_type    x_ff;
   word_type    prod_ff;
   word_type    acc_ff;
   word_type    x_in;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   word_type    mul_out;
   word_type    sum_word;

   // previous word has just landed in the tail cell
   assign x_in = tail ^ (tail >> 62);

   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = x_ff[31:0];
            mul_b = INIT_HI;
         end
         ST_MUL2: begin
            mul_a = x_ff[63:32];
            mul_b = INIT_LO;
         end
         default: begin
            mul_a = x_in[31:0];
            mul_b = INIT_LO;
         end
      endcase
   end

   assign mul_out  = {32'b0, mul_a} * {32'b0, mul_b};
   assign sum_word = acc_ff + {prod_ff[31:0], 32'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FIRST;
         idx_ff   <= '0;
      end else if (start) begin
         state_ff <= ST_FIRST;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               state_ff <= ST_IDLE;
            end
            ST_FIRST: begin
               idx_ff   <= idx_type'(1);
               state_ff <= ST_MUL0;
            end
            ST_MUL0: begin
               x_ff     <= x_in;
               prod_ff  <= mul_out;
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               acc_ff   <= prod_ff + {{(WORD_W-IDX_W){1'b0}}, idx_ff};
               prod_ff  <= mul_out;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               acc_ff   <= sum_word;
               prod_ff  <= mul_out;
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff + idx_type'(1);
                  state_ff <= ST_MUL0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign word        = (state_ff == ST_FIRST) ? seed : sum_word;
   assign status.push = (state_ff == ST_FIRST) || (state_ff == ST_PUSH);
   assign status.busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/mt64_keystream_xor_cipher_unit.sv =====
// A result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle while the result side keeps taking items.
// Reset or a seed write refills the 312-cell word chain one word at a time;
// each word is built on a shared 32x32 multiplier; req_tready is low.
// Reset is synchronous, active high; seed resets to 0 and triggers a fill.
module mt64_keystream_xor_cipher_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [63:0]           csr_wdata,   // seed
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mtk_pkg::byte_type     req_tdata,   // [7:0] data_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output mtk_pkg::byte_type     rsp_tdata    // [7:0] cipher_byte
);
   import mtk_pkg::*;

   word_type        seed_ff;
   logic            rsp_valid_ff;
   byte_type        rsp_data_ff;
   word_type        cell_q [MT_N];
   word_type        cell_d [MT_N];
   word_type        seed_word;
   seed_status_type seed_st;
   logic            shift_en;
   logic            accept;
   word_type        mix;
   word_type        twist;
   word_type        out_word;

   function automatic word_type temper(input word_type y);
      word_type t;
      t = y;
      t = t ^ ((t >> 29) & 64'h5555_5555_5555_5555);
      t = t ^ ((t << 17) & 64'h71D6_7FFF_EDA6_0000);
      t = t ^ ((t << 37) & 64'hFFF7_EEE0_0000_0000);
      t = t ^ (t >> 43);
      return t;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_we) begin
         seed_ff <= csr_wdata;
      end
   end

   mtk_seed_gen u_seed (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_we),
      .seed   (seed_ff),
      .tail   (cell_q[MT_N-1]),
      .word   (seed_word),
      .status (seed_st)
   );

   assign req_tready = !seed_st.busy && !csr_we && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign shift_en   = seed_st.push || accept;

   // head cell is word i, next cell i+1, middle tap i+156
   assign mix      = (cell_q[0] & MT_UPPER) | (cell_q[1] & MT_LOWER);
   assign twist    = cell_q[MT_M] ^ (mix >> 1) ^ (mix[0] ? MT_MATRIX : '0);
   assign out_word = temper(twist);

   genvar k;
   generate
      for (k = 0; k < MT_N; k++) begin : g_chain
         if (k == MT_N - 1) begin : g_tail
            assign cell_d[k] = seed_st.push ? seed_word : twist;
         end else begin : g_body
            assign cell_d[k] = cell_q[k+1];
         end
         mtk_cell u_cell (
            .clock (clock),
            .en    (shift_en),
            .d     (cell_d[k]),
            .q     (cell_q[k])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= req_tdata ^ out_word[63:56];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_no_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(seed_st.push && accept))
      else $error("seed push collided with item");

   a_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("input open right after seed write");

endmodule
